@@ hw/rtl/cpf_pkg.sv @@
// Package for the CRC-16 packet framer: constants, queue entry type and the CRC update.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [9:0]  MAX_PAYLOAD = 10'd512;
   localparam logic [9:0]  SHORT_MAX   = 10'd255;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [7:0]  START_SHORT = 8'd2;
   localparam logic [7:0]  START_LONG  = 8'd3;
   localparam logic [7:0]  END_BYTE    = 8'd3;
   localparam logic [7:0]  BYTE_MASK   = 8'hFF;

   typedef enum logic [1:0] {
      HDR_NONE,
      HDR_SHORT,
      HDR_LONG
   } hdr_type;

   typedef struct packed {
      hdr_type     hdr;
      logic [9:0]  length;
      logic [7:0]  data;
      logic        last;
      logic [15:0] crc;
   } entry_type;

   function automatic logic [15:0] cpf_crc_byte(input logic [15:0] crc_old,
                                                input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_old ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/crc16_packet_framer.sv @@
// Top level of the length-prefixed packet framer with CRC-16/XMODEM.
// Instantiates cpf_front, cpf_queue and cpf_back; depends on cpf_pkg.
//
// Usage: payload bytes enter on the req_ stream, one transfer per byte. The
// first byte of a packet also carries the packet length (1..1023). The rsp_
// stream carries the framed bytes: start byte 2 and a one-byte length for
// packets up to 255 bytes, else start byte 3 and a big-endian 16-bit length;
// then the payload, the big-endian CRC-16/XMODEM of the payload and end byte 3
// marked by rsp_tlast. Packets longer than 512 bytes and zero lengths are
// consumed without output.
// The first byte caused by an input transfer passes through the queue and the
// output register before it is presented on rsp_; it can transfer out at the next
// edge. The input side takes one byte per cycle while the queue has room; the
// output register sends one byte per cycle while rsp_tready is high, and since
// each packet adds header, CRC and end bytes, the output port sets sustained
// throughput.
// Reset clears packet state, empties the queue and clears the output valid flag.
// When the receiver stalls, the output byte holds, the queue fills and
// req_tready drops once QUEUE_DEPTH_P entries wait.
`timescale 1ns / 1ps
`default_nettype none

module crc16_packet_framer
   import cpf_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [7:0] payload_byte, [17:8] payload_length
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast    // frame_end
);

   logic      push, push_ready, pop, head_valid;
   entry_type push_entry, head_entry;

   cpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata[7:0]),
      .in_length  (req_tdata[17:8]),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   cpf_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   cpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_end    (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ hw/rtl/cpf_front.sv @@
// Front end of the framer: accepts payload bytes, tracks packet state and the running CRC.
// Pushes one queue entry per byte that produces output. Depends on cpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpf_front
   import cpf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_byte,
   input  wire logic [9:0] in_length,
   output logic            push,
   output entry_type       push_entry,
   input  wire logic       push_ready
);

   logic [9:0]  rem_ff, rem_in;
   logic [15:0] crc_ff, crc_in;
   logic        drop_ff, drop_in;
   logic        accept;
   logic [9:0]  rem_dec;
   logic [9:0]  len_dec;
   logic [15:0] crc_new;

   assign in_ready = push_ready;
   assign accept   = in_valid & in_ready;
   assign rem_dec  = rem_ff - 10'd1;
   assign len_dec  = in_length - 10'd1;
   assign crc_new  = cpf_crc_byte((rem_ff == 10'd0) ? 16'h0000 : crc_ff, in_byte);

   always_comb begin
      rem_in            = rem_ff;
      crc_in            = crc_ff;
      drop_in           = drop_ff;
      push              = 1'b0;
      push_entry.hdr    = HDR_NONE;
      push_entry.length = in_length;
      push_entry.data   = in_byte;
      push_entry.last   = 1'b0;
      push_entry.crc    = crc_new;
      if (accept) begin
         if (rem_ff == 10'd0) begin
            drop_in = 1'b0;
            if (in_length == 10'd0) begin
               rem_in = 10'd0;
            end else if (in_length > MAX_PAYLOAD) begin
               rem_in  = len_dec;
               drop_in = (len_dec != 10'd0);
            end else begin
               push            = 1'b1;
               push_entry.hdr  = (in_length <= SHORT_MAX) ? HDR_SHORT : HDR_LONG;
               push_entry.last = (len_dec == 10'd0);
               rem_in          = len_dec;
               crc_in          = (len_dec == 10'd0) ? 16'h0000 : crc_new;
            end
         end else if (drop_ff) begin
            rem_in  = rem_dec;
            drop_in = (rem_dec != 10'd0);
         end else begin
            push            = 1'b1;
            push_entry.last = (rem_dec == 10'd0);
            rem_in          = rem_dec;
            crc_in          = (rem_dec == 10'd0) ? 16'h0000 : crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= 10'd0;
         crc_ff  <= 16'h0000;
         drop_ff <= 1'b0;
      end else begin
         rem_ff  <= rem_in;
         crc_ff  <= crc_in;
         drop_ff <= drop_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cpf_queue.sv @@
// Short register queue between the framer front and back ends.
// Holds entry_type items from cpf_pkg; depth set by parameter.
`timescale 1ns / 1ps
`default_nettype none

module cpf_queue
   import cpf_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  entry_type  push_entry,
   output logic       push_ready,
   input  wire logic  pop,
   output logic       head_valid,
   output entry_type  head_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cpf_back.sv @@
// Back end of the framer: expands each queue entry into its payload byte, plus the header
// on a first entry, CRC and end bytes on a last. Registered output; depends on cpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpf_back
   import cpf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   output logic       out_valid,
   input  wire logic  out_ready,
   output logic [7:0] out_byte,
   output logic       out_end
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       end_ff, end_in;
   logic       load;
   logic [2:0] hdr_cnt;
   logic [2:0] last_step;
   logic [2:0] rel;
   logic [7:0] sel_byte;
   logic       sel_end;

   always_comb begin
      case (head_entry.hdr)
         HDR_SHORT: hdr_cnt = 3'd2;
         HDR_LONG:  hdr_cnt = 3'd3;
         default:   hdr_cnt = 3'd0;
      endcase
   end

   assign last_step = hdr_cnt + (head_entry.last ? 3'd3 : 3'd0);
   assign rel       = step_ff - hdr_cnt;
   assign load      = head_valid & (~valid_ff | out_ready);
   assign pop       = load & (step_ff == last_step);

   always_comb begin
      sel_end = 1'b0;
      if (step_ff < hdr_cnt) begin
         if (step_ff == 3'd0) begin
            sel_byte = (head_entry.hdr == HDR_LONG) ? START_LONG : START_SHORT;
         end else if (step_ff == 3'd1 && head_entry.hdr == HDR_LONG) begin
            sel_byte = {6'd0, head_entry.length[9:8]};
         end else begin
            sel_byte = head_entry.length[7:0] & BYTE_MASK;
         end
      end else begin
         case (rel)
            3'd0:    sel_byte = head_entry.data;
            3'd1:    sel_byte = head_entry.crc[15:8];
            3'd2:    sel_byte = head_entry.crc[7:0];
            default: begin
               sel_byte = END_BYTE;
               sel_end  = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         end_in   = sel_end;
         step_in  = pop ? 3'd0 : step_ff + 3'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_end   = end_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cpf_checker.sv @@
// Port-level assertions for crc16_packet_framer, attached by bind.
// Sees only the top-level ports; depends on cpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpf_checker
   import cpf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req transfer changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   a_end_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == END_BYTE)
      else $error("frame end not on end byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_next_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) ##1 rsp_tvalid |->
         rsp_tdata == START_SHORT || rsp_tdata == START_LONG)
      else $error("frame not opened by start byte");

endmodule

bind crc16_packet_framer cpf_checker u_cpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
